// File: hw/rtl/pidc_pkg.sv
// pidc_pkg: shared beat types, stage payloads and saturation helper for the pid block
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 8;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int FRAC_W = 16;

   localparam logic OP_CLEAR = 1'b1;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   // half an lsb of q16.16 in the q32.32 sum
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);

   typedef struct packed {
      logic [0:0]                operation;
      logic [MODE_W-1:0]         mode_index;
      logic signed [DATA_W-1:0]  measured_value;
      logic signed [DATA_W-1:0]  target_value;
      logic signed [DATA_W-1:0]  prop_gain;
      logic signed [DATA_W-1:0]  integ_gain;
      logic signed [DATA_W-1:0]  deriv_gain;
      logic signed [DATA_W-1:0]  integ_low_limit;
      logic signed [DATA_W-1:0]  integ_high_limit;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode_out;
      logic signed [DATA_W-1:0]  drive_value;
      logic                      drive_saturated;
   } rsp_type;

   // error known, state not yet looked up
   typedef struct packed {
      logic                      clear;
      logic [MODE_W-1:0]         mode;
      logic signed [DATA_W-1:0]  err;
      logic signed [DATA_W-1:0]  prop_gain;
      logic signed [DATA_W-1:0]  integ_gain;
      logic signed [DATA_W-1:0]  deriv_gain;
      logic signed [DATA_W-1:0]  low_limit;
      logic signed [DATA_W-1:0]  high_limit;
   } stage1_type;

   // multiplier operands
   typedef struct packed {
      logic                      clear;
      logic [MODE_W-1:0]         mode;
      logic signed [DATA_W-1:0]  err;
      logic signed [DATA_W-1:0]  integ;
      logic signed [DATA_W-1:0]  deriv;
      logic signed [DATA_W-1:0]  prop_gain;
      logic signed [DATA_W-1:0]  integ_gain;
      logic signed [DATA_W-1:0]  deriv_gain;
   } stage3_type;

   typedef struct packed {
      logic                      clear;
      logic [MODE_W-1:0]         mode;
      logic signed [PROD_W-1:0]  p_prop;
      logic signed [PROD_W-1:0]  p_integ;
      logic signed [PROD_W-1:0]  p_deriv;
   } stage4_type;

   typedef struct packed {
      logic                      clear;
      logic [MODE_W-1:0]         mode;
      logic signed [SUM_W-1:0]   sum;
   } stage5_type;

   // clip a one-bit-grown difference back to a data word
   function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [DATA_W:0] x);
      logic signed [DATA_W-1:0] r;
      if (x[DATA_W] != x[DATA_W-1]) begin
         r = x[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pidc_state.sv
// pidc_state: per-mode integral and previous error stores, forwarding and integrator update
`timescale 1ns / 1ps
`default_nettype none

module pidc_state #(
   parameter int NUM_MODES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   retire,
   input  pidc_pkg::stage1_type   st1_data,
   output pidc_pkg::stage3_type   st3_data
);

   localparam int IDX_W = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

   logic signed [pidc_pkg::DATA_W-1:0] integ_mem [NUM_MODES];
   logic signed [pidc_pkg::DATA_W-1:0] error_mem [NUM_MODES];
   logic [NUM_MODES-1:0]               mode_valid_ff;

   pidc_pkg::stage1_type               st2_ff;
   logic                               range_ff;
   logic signed [pidc_pkg::DATA_W-1:0] rd_integ_ff;
   logic signed [pidc_pkg::DATA_W-1:0] rd_error_ff;
   logic                               rd_valid_ff;
   logic                               fwd_hit_ff;
   logic                               fwd_hit_in;
   logic signed [pidc_pkg::DATA_W-1:0] fwd_integ_ff;
   logic signed [pidc_pkg::DATA_W-1:0] fwd_error_ff;

   logic                               rd_range;
   logic [IDX_W-1:0]                   rd_idx;
   logic [IDX_W-1:0]                   wr_idx;
   logic                               wr_en;

   logic signed [pidc_pkg::DATA_W-1:0] cur_integ;
   logic signed [pidc_pkg::DATA_W-1:0] cur_error;
   logic signed [pidc_pkg::DATA_W:0]   integ_sum;
   logic signed [pidc_pkg::DATA_W:0]   low_ext;
   logic signed [pidc_pkg::DATA_W:0]   high_ext;
   logic signed [pidc_pkg::DATA_W:0]   integ_clamp;
   logic signed [pidc_pkg::DATA_W-1:0] integ_new;
   logic signed [pidc_pkg::DATA_W:0]   deriv_diff;

   // lookup address for the beat entering this stage
   assign rd_range = 32'(st1_data.mode) < NUM_MODES;
   assign rd_idx   = rd_range ? IDX_W'(st1_data.mode) : '0;

   assign wr_idx = IDX_W'(st2_ff.mode);
   assign wr_en  = retire && !st2_ff.clear && range_ff;

   // the beat leaving now writes at the same edge the next one reads
   assign fwd_hit_in = retire &&
                       (st2_ff.clear || (wr_en && (st2_ff.mode == st1_data.mode)));

   always_ff @(posedge clock) begin
      if (load) begin
         st2_ff       <= st1_data;
         range_ff     <= rd_range;
         rd_integ_ff  <= integ_mem[rd_idx];
         rd_error_ff  <= error_mem[rd_idx];
         rd_valid_ff  <= mode_valid_ff[rd_idx];
         fwd_hit_ff   <= fwd_hit_in;
         fwd_integ_ff <= st2_ff.clear ? '0 : integ_new;
         fwd_error_ff <= st2_ff.clear ? '0 : st2_ff.err;
      end
      if (wr_en) begin
         integ_mem[wr_idx] <= integ_new;
         error_mem[wr_idx] <= st2_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_valid_ff <= '0;
      end else if (retire && st2_ff.clear) begin
         mode_valid_ff <= '0;
      end else if (wr_en) begin
         mode_valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      if (!range_ff) begin
         cur_integ = '0;
         cur_error = '0;
      end else if (fwd_hit_ff) begin
         cur_integ = fwd_integ_ff;
         cur_error = fwd_error_ff;
      end else if (rd_valid_ff) begin
         cur_integ = rd_integ_ff;
         cur_error = rd_error_ff;
      end else begin
         cur_integ = '0;
         cur_error = '0;
      end
   end

   // integrate, then low clamp, then high clamp (high wins when crossed); a zero integ gain holds the integral
   always_comb begin
      integ_sum   = (pidc_pkg::DATA_W+1)'(cur_integ) + (pidc_pkg::DATA_W+1)'(st2_ff.err);
      low_ext     = (pidc_pkg::DATA_W+1)'(st2_ff.low_limit);
      high_ext    = (pidc_pkg::DATA_W+1)'(st2_ff.high_limit);
      integ_clamp = integ_sum;
      if (integ_clamp < low_ext) begin
         integ_clamp = low_ext;
      end
      if (integ_clamp > high_ext) begin
         integ_clamp = high_ext;
      end
      if (st2_ff.integ_gain != '0) begin
         integ_new = integ_clamp[pidc_pkg::DATA_W-1:0];
      end else begin
         integ_new = cur_integ;
      end
   end

   assign deriv_diff = (pidc_pkg::DATA_W+1)'(st2_ff.err) - (pidc_pkg::DATA_W+1)'(cur_error);

   always_comb begin
      st3_data.clear      = st2_ff.clear;
      st3_data.mode       = st2_ff.mode;
      st3_data.err        = st2_ff.err;
      st3_data.integ      = integ_new;
      st3_data.deriv      = pidc_pkg::sat_word(deriv_diff);
      st3_data.prop_gain  = st2_ff.prop_gain;
      st3_data.integ_gain = st2_ff.integ_gain;
      st3_data.deriv_gain = st2_ff.deriv_gain;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pidc_mult.sv
// pidc_mult: operand register and the three gain products
`timescale 1ns / 1ps
`default_nettype none

module pidc_mult (
   input  logic                   clock,
   input  logic                   load,
   input  pidc_pkg::stage3_type   st3_in,
   output pidc_pkg::stage4_type   st4_data
);

   pidc_pkg::stage3_type st3_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         st3_ff <= st3_in;
      end
   end

   // q16.16 times q16.16 gives exact q32.32
   always_comb begin
      st4_data.clear   = st3_ff.clear;
      st4_data.mode    = st3_ff.mode;
      st4_data.p_prop  = st3_ff.prop_gain * st3_ff.err;
      st4_data.p_integ = st3_ff.integ_gain * st3_ff.integ;
      st4_data.p_deriv = st3_ff.deriv_gain * st3_ff.deriv;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pidc_round.sv
// pidc_round: product sum with rounding bias, then q16.16 extraction and saturation
`timescale 1ns / 1ps
`default_nettype none

module pidc_round (
   input  logic                   clock,
   input  logic                   load_sum,
   input  logic                   load_sat,
   input  pidc_pkg::stage4_type   st4_in,
   output pidc_pkg::rsp_type      rsp_in
);

   localparam int SUM_W  = pidc_pkg::SUM_W;
   localparam int TOP_LO = pidc_pkg::FRAC_W + pidc_pkg::DATA_W - 1;

   pidc_pkg::stage4_type st4_ff;
   pidc_pkg::stage5_type st5_ff;
   pidc_pkg::stage5_type st5_in;
   logic                 fits;

   always_ff @(posedge clock) begin
      if (load_sum) begin
         st4_ff <= st4_in;
      end
      if (load_sat) begin
         st5_ff <= st5_in;
      end
   end

   // round to nearest, ties up: floor((p + half) / 2^16)
   always_comb begin
      st5_in.clear = st4_ff.clear;
      st5_in.mode  = st4_ff.mode;
      st5_in.sum   = SUM_W'(st4_ff.p_prop) + SUM_W'(st4_ff.p_integ)
                   + SUM_W'(st4_ff.p_deriv) + pidc_pkg::ROUND_BIAS;
   end

   // result fits when every bit above the q16.16 word copies its sign
   assign fits = (&st5_ff.sum[SUM_W-1:TOP_LO]) || !(|st5_ff.sum[SUM_W-1:TOP_LO]);

   always_comb begin
      rsp_in.mode_out = st5_ff.mode;
      if (st5_ff.clear) begin
         rsp_in.drive_value     = '0;
         rsp_in.drive_saturated = 1'b0;
      end else if (fits) begin
         rsp_in.drive_value     = st5_ff.sum[TOP_LO:pidc_pkg::FRAC_W];
         rsp_in.drive_saturated = 1'b0;
      end else begin
         rsp_in.drive_value     = st5_ff.sum[SUM_W-1] ? pidc_pkg::DATA_MIN
                                                      : pidc_pkg::DATA_MAX;
         rsp_in.drive_saturated = 1'b1;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/per_mode_pid_with_integral_clamp_top.sv
// per_mode_pid_with_integral_clamp_top: pipelined per-mode pid controller with integrator clamp
//
// usage
//   req channel: one beat per sample (operation 0) or per clear (operation 1),
//   carrying mode index, measurement, setpoint, three q16.16 gains and the
//   integral limits. rsp channel: one beat per req beat, in order, with the
//   mode echoed, the q16.16 drive and a flag when the drive was clipped.
//   flow: a beat passes the input, state, operand, product, sum and output
//   registers in order. throughput: one beat per cycle while rsp_ready
//   keeps up, back to back, also on the same mode; the per-mode integral and
//   previous error are a read-modify-write in the state stage, with a bypass
//   for the beat right behind. a clear beat zeroes every mode's state (valid
//   bits drop at once) and returns drive 0.
//   reset: synchronous; empties the pipeline and marks every mode as unwritten,
//   so all integrals and previous errors read as zero. no clearing pass.
//   stall: each stage holds while the one after it is full and held, so a
//   waiting rsp beat does not stop req beats until the bubbles ahead are used
//   up; with rsp_ready low for good, six beats are taken and then req_ready
//   drops.
`timescale 1ns / 1ps
`default_nettype none

module per_mode_pid_with_integral_clamp_top #(
   parameter int NUM_MODES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pidc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pidc_pkg::rsp_type   rsp_data
);

   // stage valid flags: 1 input, 2 state, 3 operands, 4 products, 5 sum, 6 output
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic ld1, ld2, ld3, ld4, ld5, ldo;

   pidc_pkg::req_type                  req_ff;
   pidc_pkg::stage1_type               st1_data;
   pidc_pkg::stage3_type               st3_data;
   pidc_pkg::stage4_type               st4_data;
   pidc_pkg::rsp_type                  rsp_in;
   pidc_pkg::rsp_type                  rsp_ff;
   logic signed [pidc_pkg::DATA_W:0]   err_diff;

   // a stage loads when empty or when its beat moves on
   assign ldo = !vo_ff || rsp_ready;
   assign ld5 = !v5_ff || ldo;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_ready = ld1;
   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
         if (ldo) vo_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         req_ff <= req_data;
      end
      if (ldo) begin
         rsp_ff <= rsp_in;
      end
   end

   // error is independent of stored state, so it is formed ahead of the lookup
   assign err_diff = (pidc_pkg::DATA_W+1)'(req_ff.measured_value)
                   - (pidc_pkg::DATA_W+1)'(req_ff.target_value);

   always_comb begin
      st1_data.clear      = (req_ff.operation == pidc_pkg::OP_CLEAR);
      st1_data.mode       = req_ff.mode_index;
      st1_data.err        = pidc_pkg::sat_word(err_diff);
      st1_data.prop_gain  = req_ff.prop_gain;
      st1_data.integ_gain = req_ff.integ_gain;
      st1_data.deriv_gain = req_ff.deriv_gain;
      st1_data.low_limit  = req_ff.integ_low_limit;
      st1_data.high_limit = req_ff.integ_high_limit;
   end

   pidc_state #(
      .NUM_MODES (NUM_MODES)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .load     (ld2),
      .retire   (v2_ff && ld3),
      .st1_data (st1_data),
      .st3_data (st3_data)
   );

   pidc_mult u_mult (
      .clock    (clock),
      .load     (ld3),
      .st3_in   (st3_data),
      .st4_data (st4_data)
   );

   pidc_round u_round (
      .clock    (clock),
      .load_sum (ld4),
      .load_sat (ld5),
      .st4_in   (st4_data),
      .rsp_in   (rsp_in)
   );

`ifndef SYNTHESIS
   // an empty output stage never holds back the input
   a_empty_out_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   // reset flushes every beat in flight
   a_reset_flushes: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat shown right after reset");

   // a clipped drive sits at one of the rails
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_saturated |->
         (rsp_data.drive_value == pidc_pkg::DATA_MAX) ||
         (rsp_data.drive_value == pidc_pkg::DATA_MIN))
      else $error("saturated drive not at a rail");

   // an accepted beat always lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted req beat lost");
`endif

endmodule

`default_nettype wire
